// ===== sv/bisection_order_index_map_defines.svh =====
// Assertion macros shared by the bisection order index map RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BISECTION_ORDER_INDEX_MAP_DEFINES_SVH
`define BISECTION_ORDER_INDEX_MAP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BOM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BOM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bom_pkg.sv =====
// Shared types, constants and helper functions of the bisection order index map.
// Depends on nothing; imported by every module of the block.
package bom_pkg;

    localparam int POS_W               = 30;
    localparam int IDX_W               = 34;
    localparam int BASE_W              = 32;
    localparam int LIM_W               = 31;
    localparam int LOG_W               = 4;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 32;
    localparam int MAX_LOG2_EXTENT_DEF = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_Z      = 3'd4;

    typedef struct packed {
        logic [BASE_W-1:0] base_offset;
        logic [LIM_W-1:0]  leaf_volume_limit;
        logic [LOG_W-1:0]  log2_size_x;
        logic [LOG_W-1:0]  log2_size_y;
        logic [LOG_W-1:0]  log2_size_z;
    } t_cfg;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_walk_state;

    typedef struct packed {
        logic done;
        logic invalid;
    } t_walk_res;

    function automatic int clamp_log(input logic [LOG_W-1:0] v, input int max_v);
        return (int'(v) > max_v) ? max_v : int'(v);
    endfunction

    // Number of position bits walked per item.
    function automatic int walk_width(input int max_log);
        return (3 * max_log > POS_W) ? 3 * max_log : POS_W;
    endfunction

endpackage

// ===== sv/bisection_order_index_map.sv =====
// Operation: the walk shifts one position bit per cycle over max(30, 3*MAX_LOG2_EXTENT) bits,
// followed by two adder stages; a new transaction is accepted only while busy is low.
// Reset: synchronous, active low; clears all configuration registers and control state.
// The result is flagged for exactly one cycle by o_result_strobe; the outputs hold until the next result.
// Top level of the bisection order index map; depends on bom_pkg, bom_cfg, bom_walk, bom_sum.
module bisection_order_index_map #(
    parameter int MAX_LOG2_EXTENT = bom_pkg::MAX_LOG2_EXTENT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bom_pkg::POS_W-1:0]       i_local_position,
    output logic                            o_result_strobe,
    output logic [bom_pkg::IDX_W-1:0]       o_global_index,
    output logic [bom_pkg::IDX_W-1:0]       o_second_component_index,
    output logic [bom_pkg::IDX_W-1:0]       o_third_component_index,
    output logic                            o_position_invalid,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bom_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bom_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bom_pkg::*;

    localparam int TW = walk_width(MAX_LOG2_EXTENT);

    t_cfg          w_cfg;
    t_walk_res     w_res;
    logic [TW-1:0] w_raster;
    logic          w_walk_busy;
    logic          w_sum_busy;
    logic          w_accept;

    assign busy     = w_walk_busy | w_sum_busy;
    assign w_accept = start & ~busy;

    bom_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bom_walk #(
        .MAX_LOG2_EXTENT (MAX_LOG2_EXTENT)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_position (i_local_position),
        .i_cfg      (w_cfg),
        .o_busy     (w_walk_busy),
        .o_res      (w_res),
        .o_raster   (w_raster)
    );

    bom_sum #(
        .MAX_LOG2_EXTENT (MAX_LOG2_EXTENT)
    ) u_sum (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_res                    (w_res),
        .i_raster                 (w_raster),
        .i_cfg                    (w_cfg),
        .o_busy                   (w_sum_busy),
        .o_strobe                 (o_result_strobe),
        .o_global_index           (o_global_index),
        .o_second_component_index (o_second_component_index),
        .o_third_component_index  (o_third_component_index),
        .o_position_invalid       (o_position_invalid)
    );

endmodule

// ===== sv/bom_cfg.sv =====
// Configuration register file of the bisection order index map.
// Depends on bom_pkg for the register indexes and the configuration struct.
module bom_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bom_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bom_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output bom_pkg::t_cfg                   o_cfg
);
    import bom_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_OFFSET: r_cfg.base_offset       <= i_cfg_data[BASE_W-1:0];
                CFG_LEAF_LIMIT:  r_cfg.leaf_volume_limit <= i_cfg_data[LIM_W-1:0];
                CFG_LOG2_X:      r_cfg.log2_size_x       <= i_cfg_data[LOG_W-1:0];
                CFG_LOG2_Y:      r_cfg.log2_size_y       <= i_cfg_data[LOG_W-1:0];
                CFG_LOG2_Z:      r_cfg.log2_size_z       <= i_cfg_data[LOG_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/bom_walk.sv =====
// Bit-serial bisection walk: shifts the position out MSB first and scatters each bit
// into the raster index. Depends on bom_pkg and the shared assertion macro header.
`include "bisection_order_index_map_defines.svh"
module bom_walk #(
    parameter int MAX_LOG2_EXTENT = bom_pkg::MAX_LOG2_EXTENT_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  logic [bom_pkg::POS_W-1:0]                      i_position,
    input  bom_pkg::t_cfg                                  i_cfg,
    output logic                                           o_busy,
    output bom_pkg::t_walk_res                             o_res,
    output logic [bom_pkg::walk_width(MAX_LOG2_EXTENT)-1:0] o_raster
);
    import bom_pkg::*;

    localparam int TW = walk_width(MAX_LOG2_EXTENT);
    localparam int SW = $clog2(TW + 1);
    localparam int DW = $clog2(TW);
    localparam int CW = $clog2(MAX_LOG2_EXTENT + 1);

    t_walk_state      r_state, n_state;
    logic [SW-1:0]    r_t, n_t;
    logic [TW-1:0]    r_p, n_p;
    logic [TW:0]      r_lim, n_lim;
    logic             r_leaf, n_leaf;
    logic [CW-1:0]    r_a, n_a;
    logic [CW-1:0]    r_b, n_b;
    logic [CW-1:0]    r_c, n_c;
    logic [TW-1:0]    r_ras, n_ras;
    logic             r_inv, n_inv;
    logic             r_done, n_done;

    logic [CW-1:0]    w_lx, w_ly, w_lz;
    logic [SW-1:0]    w_ltot;
    logic [SW:0]      w_abc;
    logic [LIM_W-1:0] w_limit;
    logic             w_bit;
    logic             w_leaf_now;
    logic [SW-1:0]    w_dest;
    logic             w_write;

    assign w_lx    = CW'(clamp_log(i_cfg.log2_size_x, MAX_LOG2_EXTENT));
    assign w_ly    = CW'(clamp_log(i_cfg.log2_size_y, MAX_LOG2_EXTENT));
    assign w_lz    = CW'(clamp_log(i_cfg.log2_size_z, MAX_LOG2_EXTENT));
    assign w_ltot  = SW'(w_lx) + SW'(w_ly) + SW'(w_lz);
    assign w_abc   = (SW + 1)'(r_a) + (SW + 1)'(r_b) + (SW + 1)'(r_c);
    assign w_limit = (i_cfg.leaf_volume_limit == '0) ? LIM_W'(1) : i_cfg.leaf_volume_limit;

    assign o_busy   = (r_state == S_RUN);
    assign o_res    = '{done: r_done, invalid: r_inv};
    assign o_raster = r_ras;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_t    <= n_t;
        r_p    <= n_p;
        r_lim  <= n_lim;
        r_leaf <= n_leaf;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_ras  <= n_ras;
        r_inv  <= n_inv;
    end

    always_comb begin
        n_state    = r_state;
        n_t        = r_t;
        n_p        = r_p;
        n_lim      = r_lim;
        n_leaf     = r_leaf;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_ras      = r_ras;
        n_inv      = r_inv;
        n_done     = 1'b0;
        w_bit      = r_p[TW-1];
        w_leaf_now = r_leaf | r_lim[TW];
        w_dest     = '0;
        w_write    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_t     = SW'(TW - 1);
                    n_p     = TW'(i_position);
                    n_lim   = (TW + 1)'(w_limit);
                    n_leaf  = 1'b0;
                    n_a     = w_lx;
                    n_b     = w_ly;
                    n_c     = w_lz;
                    n_ras   = '0;
                    n_inv   = 1'b0;
                end
            end
            S_RUN: begin
                n_p    = r_p << 1;
                n_lim  = r_lim << 1;
                n_leaf = w_leaf_now;
                if (r_t >= w_ltot) begin
                    if (w_bit) begin
                        n_inv = 1'b1;
                    end
                end else if (!w_leaf_now) begin
                    w_write = w_bit;
                    if (r_a > r_b && r_a > r_c) begin
                        n_a    = r_a - 1'b1;
                        w_dest = SW'(n_a);
                    end else if (r_b > r_c) begin
                        n_b    = r_b - 1'b1;
                        w_dest = SW'(w_lx) + SW'(n_b);
                    end else begin
                        n_c    = r_c - 1'b1;
                        w_dest = SW'(w_lx) + SW'(w_ly) + SW'(n_c);
                    end
                end else begin
                    w_write = w_bit;
                    w_dest  = r_t;
                    if (r_t >= SW'(r_a)) begin
                        w_dest = w_dest + SW'(w_lx) - SW'(r_a);
                    end
                    if (r_t >= SW'(r_a) + SW'(r_b)) begin
                        w_dest = w_dest + SW'(w_ly) - SW'(r_b);
                    end
                end
                if (w_write) begin
                    n_ras[w_dest[DW-1:0]] = 1'b1;
                end
                if (r_t == '0) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_t = r_t - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `BOM_ASSERT_NEXT(a_walk_finishes, i_clk, i_rst_n, r_state == S_RUN && r_t == '0, r_done && r_state == S_IDLE, "walk did not finish after its last bit")
    `BOM_ASSERT_NOW(a_box_holds_bit, i_clk, i_rst_n, r_state == S_RUN && r_t < w_ltot, (SW + 1)'(r_t) < w_abc, "current bit lies outside the remaining box")
    `BOM_ASSERT_NOW(a_raster_in_grid, i_clk, i_rst_n, r_done, (r_ras >> w_ltot) == '0, "raster index exceeds the grid volume")

endmodule

// ===== sv/bom_sum.sv =====
// Output stage: adds the base offset and the component strides to the raster index.
// Depends on bom_pkg for widths, the configuration struct and the walk result.
module bom_sum #(
    parameter int MAX_LOG2_EXTENT = bom_pkg::MAX_LOG2_EXTENT_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  bom_pkg::t_walk_res                             i_res,
    input  logic [bom_pkg::walk_width(MAX_LOG2_EXTENT)-1:0] i_raster,
    input  bom_pkg::t_cfg                                  i_cfg,
    output logic                                           o_busy,
    output logic                                           o_strobe,
    output logic [bom_pkg::IDX_W-1:0]                      o_global_index,
    output logic [bom_pkg::IDX_W-1:0]                      o_second_component_index,
    output logic [bom_pkg::IDX_W-1:0]                      o_third_component_index,
    output logic                                           o_position_invalid
);
    import bom_pkg::*;

    localparam int TW = walk_width(MAX_LOG2_EXTENT);
    localparam int SW = $clog2(TW + 1);

    logic [SW-1:0]         w_ltot;
    logic [IDX_W:0]        w_one_sh;
    logic [IDX_W:0]        w_two_sh;
    logic [TW+IDX_W-1:0]   w_ras_ext;

    logic                  r_v1;
    logic                  r_inv1;
    logic [IDX_W-1:0]      r_g;
    logic                  r_strobe;
    logic [IDX_W-1:0]      r_gi;
    logic [IDX_W-1:0]      r_si;
    logic [IDX_W-1:0]      r_ti;
    logic                  r_pinv;

    assign w_ltot = SW'(clamp_log(i_cfg.log2_size_x, MAX_LOG2_EXTENT))
                  + SW'(clamp_log(i_cfg.log2_size_y, MAX_LOG2_EXTENT))
                  + SW'(clamp_log(i_cfg.log2_size_z, MAX_LOG2_EXTENT));
    assign w_one_sh  = (IDX_W + 1)'(1) << w_ltot;
    assign w_two_sh  = (IDX_W + 1)'(2) << w_ltot;
    assign w_ras_ext = (TW + IDX_W)'(i_raster);

    assign o_busy                   = i_res.done | r_v1;
    assign o_strobe                 = r_strobe;
    assign o_global_index           = r_gi;
    assign o_second_component_index = r_si;
    assign o_third_component_index  = r_ti;
    assign o_position_invalid       = r_pinv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= i_res.done;
            r_strobe <= r_v1;
        end
        if (i_res.done) begin
            r_g    <= IDX_W'(i_cfg.base_offset) + w_ras_ext[IDX_W-1:0];
            r_inv1 <= i_res.invalid;
        end
        if (r_v1) begin
            r_pinv <= r_inv1;
            if (r_inv1) begin
                r_gi <= '0;
                r_si <= '0;
                r_ti <= '0;
            end else begin
                r_gi <= r_g;
                r_si <= r_g + w_one_sh[IDX_W-1:0];
                r_ti <= r_g + w_two_sh[IDX_W-1:0];
            end
        end
    end

endmodule
